>>> rtl/assert_macros.svh
// Assertion macros shared by the loader RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define OIBL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("loader assertion failed");

// Same, with a message of the caller's choosing.
`define OIBL_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

`endif

>>> rtl/oibl_pkg.sv
// Types and constants of the object image block loader.
package oibl_pkg;

    localparam int MEMORY_BYTES = 131072;
    localparam int ADDR_W       = 17;
    localparam int BOUND_W      = 18;

    localparam logic [ADDR_W-1:0]  MEM_LAST     = ADDR_W'(MEMORY_BYTES - 1);
    localparam logic [BOUND_W-1:0] LOW_RESET    = BOUND_W'(MEMORY_BYTES);
    localparam logic [15:0]        MAGIC_RESET  = 16'h7962;
    localparam logic [2:0]         MIN_FILE_BYTES = 3'd7;

    typedef enum logic [2:0] {
        PH_MAGIC_HI,
        PH_MAGIC_LO,
        PH_HEADER,
        PH_DATA,
        PH_FAILED
    } t_phase;

    typedef enum logic [1:0] {
        ST_BUSY       = 2'd0,
        ST_ACCEPTED   = 2'd1,
        ST_NOT_OBJECT = 2'd2,
        ST_CORRUPT    = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic               write_enable;
        logic [ADDR_W-1:0]  write_address;
        logic [7:0]         write_data;
        t_status            status;
        logic [BOUND_W-1:0] low_bound;
        logic [ADDR_W-1:0]  high_bound;
    } t_result;

endpackage

>>> rtl/oibl_in_if.sv
// Input channel: one file byte per item.
interface oibl_in_if;
    import oibl_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

>>> rtl/oibl_out_if.sv
// Output channel: one memory write and status result per item.
interface oibl_out_if;
    import oibl_pkg::*;

    logic               valid;
    logic               ready;
    logic               write_enable;
    logic [ADDR_W-1:0]  write_address;
    logic [7:0]         write_data;
    logic [1:0]         status;
    logic [BOUND_W-1:0] low_bound;
    logic [ADDR_W-1:0]  high_bound;

    modport source (output valid, output write_enable, output write_address,
                    output write_data, output status, output low_bound,
                    output high_bound, input ready);
    modport sink (input valid, input write_enable, input write_address,
                  input write_data, input status, input low_bound,
                  input high_bound, output ready);
endinterface

>>> rtl/oibl_in_stage.sv
// Input register stage of the loader.
module oibl_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    oibl_in_if.sink           i_in,
    input  logic              i_advance,
    output logic              o_valid,
    output oibl_pkg::t_in_item o_item
);
    import oibl_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign i_in.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.in_byte   <= i_in.in_byte;
            r_item.last_byte <= i_in.last_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

>>> rtl/oibl_parser.sv
// File parser: phase tracking, block headers, write addresses and bounds.
`include "assert_macros.svh"

module oibl_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  oibl_pkg::t_in_item i_item,
    input  logic [15:0]        i_magic,
    output oibl_pkg::t_result  o_result
);
    import oibl_pkg::*;

    t_phase              r_phase, n_phase, step_phase;
    logic [2:0]          r_bytes_seen, n_bytes_seen;
    logic [7:0]          r_magic_high, n_magic_high;
    logic [1:0]          r_hdr_idx, n_hdr_idx;
    logic [15:0]         r_addr, n_addr;
    logic [15:0]         r_remaining, n_remaining;
    logic [ADDR_W-1:0]   r_ptr, n_ptr;
    logic [BOUND_W-1:0]  r_low, n_low, step_low;
    logic [ADDR_W-1:0]   r_high, n_high, step_high;
    logic [15:0]         count_full;
    logic                truncated;
    logic                last;
    logic [7:0]          b;

    assign b          = i_item.in_byte;
    assign last       = i_item.last_byte;
    assign count_full = {r_remaining[15:8], b};
    // The final byte cannot complete a block that still needs more than one byte.
    assign truncated  = last && (r_remaining[15:1] != 15'd0);

    // Next phase.
    always_comb begin
        step_phase = r_phase;
        unique case (r_phase)
            PH_MAGIC_HI: step_phase = PH_MAGIC_LO;
            PH_MAGIC_LO: step_phase = ({r_magic_high, b} != i_magic) ? PH_FAILED : PH_HEADER;
            PH_HEADER: begin
                if (r_hdr_idx == 2'd3 && count_full != 16'd0) begin
                    step_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (!truncated && r_remaining == 16'd1) begin
                    step_phase = PH_HEADER;
                end
            end
            PH_FAILED: step_phase = PH_FAILED;
            default:   step_phase = PH_FAILED;
        endcase
        n_phase = last ? PH_MAGIC_HI : step_phase;
    end

    // Datapath and result.
    always_comb begin
        n_bytes_seen = (r_bytes_seen < MIN_FILE_BYTES) ? r_bytes_seen + 3'd1 : r_bytes_seen;
        n_magic_high = r_magic_high;
        n_hdr_idx    = r_hdr_idx;
        n_addr       = r_addr;
        n_remaining  = r_remaining;
        n_ptr        = r_ptr;
        step_low     = r_low;
        step_high    = r_high;
        o_result     = '0;

        case (r_phase)
            PH_MAGIC_HI: n_magic_high = b;
            PH_MAGIC_LO: n_hdr_idx = 2'd0;
            PH_HEADER: begin
                n_hdr_idx = r_hdr_idx + 2'd1;
                case (r_hdr_idx)
                    2'd0: n_addr = {b, 8'h00};
                    2'd1: n_addr = {r_addr[15:8], b};
                    2'd2: n_remaining = {b, 8'h00};
                    default: begin
                        n_remaining = count_full;
                        if (count_full != 16'd0) begin
                            n_ptr = ADDR_W'(r_addr);
                            if (BOUND_W'(r_addr) < r_low) begin
                                step_low = BOUND_W'(r_addr);
                            end
                        end
                    end
                endcase
            end
            PH_DATA: begin
                if (!truncated) begin
                    o_result.write_enable  = 1'b1;
                    o_result.write_address = r_ptr;
                    o_result.write_data    = b;
                    if (r_ptr > r_high) begin
                        step_high = r_ptr;
                    end
                    n_ptr       = (r_ptr == MEM_LAST) ? '0 : r_ptr + ADDR_W'(1);
                    n_remaining = r_remaining - 16'd1;
                    if (r_remaining == 16'd1) begin
                        n_hdr_idx = 2'd0;
                    end
                end
            end
            default: ;
        endcase

        o_result.low_bound  = step_low;
        o_result.high_bound = step_high;
        o_result.status     = ST_BUSY;
        if (last) begin
            if (n_bytes_seen < MIN_FILE_BYTES) begin
                o_result.status = ST_NOT_OBJECT;
            end else if (step_phase == PH_FAILED) begin
                o_result.status = ST_NOT_OBJECT;
            end else if (step_phase == PH_DATA) begin
                o_result.status = ST_CORRUPT;
            end else begin
                o_result.status = ST_ACCEPTED;
            end
        end

        n_low  = step_low;
        n_high = step_high;
        // The final byte ends the file; the next byte starts a new one.
        if (last) begin
            n_bytes_seen = '0;
            n_magic_high = '0;
            n_hdr_idx    = '0;
            n_addr       = '0;
            n_remaining  = '0;
            n_ptr        = '0;
            n_low        = LOW_RESET;
            n_high       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_MAGIC_HI;
            r_bytes_seen <= '0;
            r_magic_high <= '0;
            r_hdr_idx    <= '0;
            r_addr       <= '0;
            r_remaining  <= '0;
            r_ptr        <= '0;
            r_low        <= LOW_RESET;
            r_high       <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bytes_seen <= n_bytes_seen;
            r_magic_high <= n_magic_high;
            r_hdr_idx    <= n_hdr_idx;
            r_addr       <= n_addr;
            r_remaining  <= n_remaining;
            r_ptr        <= n_ptr;
            r_low        <= n_low;
            r_high       <= n_high;
        end
    end

    `OIBL_ASSERT(a_write_status_ok, i_clk, i_rst_n,
        i_step && o_result.write_enable |->
        (o_result.status == ST_BUSY || o_result.status == ST_ACCEPTED))
    `OIBL_ASSERT_MSG(a_clear_after_last, i_clk, i_rst_n,
        i_step && last |=> (r_phase == PH_MAGIC_HI && r_bytes_seen == 3'd0),
        "file state not cleared after final byte")
    `OIBL_ASSERT(a_data_has_bytes, i_clk, i_rst_n,
        r_phase == PH_DATA |-> r_remaining != 16'd0)
endmodule

>>> rtl/oibl_out_stage.sv
// Result register stage of the loader.
module oibl_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  oibl_pkg::t_result i_result,
    output logic              o_ready,
    oibl_out_if.source        o_out
);
    import oibl_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_ready) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.write_enable  = r_result.write_enable;
    assign o_out.write_address = r_result.write_address;
    assign o_out.write_data    = r_result.write_data;
    assign o_out.status        = r_result.status;
    assign o_out.low_bound     = r_result.low_bound;
    assign o_out.high_bound    = r_result.high_bound;

    `OIBL_ASSERT(a_load_needs_room, i_clk, i_rst_n,
        r_valid && !o_out.ready |=> r_valid)
endmodule

>>> rtl/object_image_block_loader_core.sv
// Top level of the object image block loader.
// Each accepted byte passes from the input register through the parser into the result register.
// Throughput: one byte per cycle; the result register stalls the input only when full and not taken.
// The input register and the result register bound the single parser step.
// Synchronous active-low reset clears all file state and sets the magic to 0x7962.
module object_image_block_loader_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    oibl_in_if.sink     i_in,
    oibl_out_if.source  o_out
);
    import oibl_pkg::*;

    logic [15:0] r_magic;
    logic        stage_valid;
    t_in_item    stage_item;
    logic        out_room;
    logic        advance;
    t_result     result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= MAGIC_RESET;
        end else if (i_cfg_we) begin
            r_magic <= i_cfg_wdata;
        end
    end

    assign advance = stage_valid && out_room;

    oibl_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    oibl_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (stage_item),
        .i_magic  (r_magic),
        .o_result (result)
    );

    oibl_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (result),
        .o_ready  (out_room),
        .o_out    (o_out)
    );
endmodule
